[rtl/ptrd_pkg.sv]
// ============================================================================
// ptrd_pkg
// Shared types and constants of the periodic task release dispatcher.
// ============================================================================
`default_nettype none

package ptrd_pkg;

   // task set and counter sizing
   localparam int NUM_REGS   = 5;
   localparam int NUM_TASKS  = 5;
   localparam int COUNT_BITS = 12;
   localparam int IDX_W      = 3;

   // timing register layout: period in the low field, start offset above it
   localparam int FIELD_BITS = 12;
   localparam int TIMING_W   = 2 * FIELD_BITS;

   // configuration port
   localparam int DATA_W    = 32;
   localparam int ADDR_W    = $clog2(4 * NUM_REGS);
   localparam int REG_IDX_W = ADDR_W - 2;

   // stream payload widths
   localparam int REQ_DATA_W  = 8;
   localparam int REQ_USER_W  = 1;
   localparam int RSP_FIELD_W = 7;
   localparam int RSP_DATA_W  = 8;

   // command codes
   localparam logic CMD_TICK   = 1'b0;
   localparam logic CMD_REPORT = 1'b1;

   // reset timing: tick rate over task rates
   localparam int TICK_RATE   = 3000;
   localparam int RATE_FAST   = 1500;
   localparam int RATE_FULL   = 3000;
   localparam int RATE_SLOW   = 600;
   localparam int PERIOD_FAST = TICK_RATE / RATE_FAST;
   localparam int PERIOD_FULL = TICK_RATE / RATE_FULL;
   localparam int PERIOD_SLOW = TICK_RATE / RATE_SLOW;

   localparam logic [NUM_REGS-1:0][TIMING_W-1:0] TIMING_RESET = {
      TIMING_W'((1 << FIELD_BITS) | PERIOD_SLOW),
      TIMING_W'((2 << FIELD_BITS) | PERIOD_FULL),
      TIMING_W'((2 << FIELD_BITS) | PERIOD_FULL),
      TIMING_W'((2 << FIELD_BITS) | PERIOD_FULL),
      TIMING_W'((1 << FIELD_BITS) | PERIOD_FAST)
   };

   typedef logic [NUM_REGS-1:0][TIMING_W-1:0] timing_arr_type;

   // one accepted input item
   typedef struct packed {
      logic cmd;
      logic task_done;
   } item_type;

   // register write toward the core
   typedef struct packed {
      logic                 en;
      logic [REG_IDX_W-1:0] idx;
      logic [TIMING_W-1:0]  value;
   } cfg_wr_type;

   // one result item
   typedef struct packed {
      logic             tick_overrun;
      logic             all_done;
      logic             new_pass;
      logic [IDX_W-1:0] task_index;
      logic             dispatch_valid;
   } result_type;

endpackage

`default_nettype wire

[rtl/periodic_task_release_dispatcher_unit.sv]
// ============================================================================
// periodic_task_release_dispatcher_unit
// Tick-driven periodic task release and priority-order dispatch.
// ============================================================================
//
//   port group  direction  transfer content
//   req_*       in         tick or completion report, one per transfer
//   rsp_*       out        one dispatch result per request
//   csr_*       in/out     five per-task timing registers, 4-byte stride
//
// One request per cycle sustained while the result is taken; a stalled result
// holds the request in the input register. An accepted request goes from the
// input register through one pass of the countdown and priority-search logic
// into the result register, from which its result is offered.
// Reset is synchronous; it empties both registers, loads default timing and
// start offsets into the countdowns, and clears the pending mask, cursor and
// deferred tick.
// A stalled result holds; the input register still drains into the result
// register when the result is taken in the same cycle.
// ============================================================================
`default_nettype none

module periodic_task_release_dispatcher_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // req_tdata: [0] task_done
   input  wire logic [ptrd_pkg::REQ_DATA_W-1:0]   req_tdata,
   // req_tuser: [0] cmd
   input  wire logic [ptrd_pkg::REQ_USER_W-1:0]   req_tuser,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // rsp_tdata: [0] dispatch_valid, [3:1] task_index, [4] new_pass,
   //            [5] all_done, [6] tick_overrun
   output logic      [ptrd_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [ptrd_pkg::ADDR_W-1:0]       csr_paddr,
   input  wire logic [ptrd_pkg::DATA_W-1:0]       csr_pwdata,
   output logic      [ptrd_pkg::DATA_W-1:0]       csr_prdata,
   output logic                                   csr_pready
);

   ptrd_pkg::item_type          item_ff;
   logic                        in_valid_ff;
   ptrd_pkg::result_type        rsp_ff;
   logic                        out_valid_ff;
   ptrd_pkg::result_type        result;
   ptrd_pkg::timing_arr_type    timing;
   ptrd_pkg::cfg_wr_type        cfg_wr;
   logic                        advance;

   // handshake control
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   ptrd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .timing      (timing),
      .cfg_wr      (cfg_wr)
   );

   ptrd_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item_ff),
      .timing  (timing),
      .cfg_wr  (cfg_wr),
      .result  (result)
   );

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         item_ff.cmd       <= req_tuser[0];
         item_ff.task_done <= req_tdata[0];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = ptrd_pkg::RSP_DATA_W'(rsp_ff);

endmodule

`default_nettype wire

[rtl/ptrd_csr.sv]
// ============================================================================
// ptrd_csr
// Timing registers behind the APB-style configuration port.
// ============================================================================
`default_nettype none

module ptrd_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [ptrd_pkg::ADDR_W-1:0]    csr_paddr,
   input  wire logic [ptrd_pkg::DATA_W-1:0]    csr_pwdata,
   output logic      [ptrd_pkg::DATA_W-1:0]    csr_prdata,
   output logic                                csr_pready,
   output ptrd_pkg::timing_arr_type            timing,
   output ptrd_pkg::cfg_wr_type                cfg_wr
);

   ptrd_pkg::timing_arr_type              timing_ff;
   ptrd_pkg::timing_arr_type              timing_in;
   logic [ptrd_pkg::REG_IDX_W-1:0]        reg_idx;
   logic                                  idx_ok;
   logic                                  wr_fire;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[ptrd_pkg::ADDR_W-1:2];
   assign idx_ok     = (int'(reg_idx) < ptrd_pkg::NUM_REGS);
   assign wr_fire    = csr_psel && csr_penable && csr_pwrite && idx_ok;

   // register write
   always_comb begin
      timing_in = timing_ff;
      if (wr_fire) begin
         timing_in[reg_idx] = csr_pwdata[ptrd_pkg::TIMING_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timing_ff <= ptrd_pkg::TIMING_RESET;
      end else begin
         timing_ff <= timing_in;
      end
   end

   // read back
   always_comb begin
      csr_prdata = '0;
      if (idx_ok) begin
         csr_prdata = ptrd_pkg::DATA_W'(timing_ff[reg_idx]);
      end
   end

   assign timing       = timing_ff;
   assign cfg_wr.en    = wr_fire;
   assign cfg_wr.idx   = reg_idx;
   assign cfg_wr.value = csr_pwdata[ptrd_pkg::TIMING_W-1:0];

endmodule

`default_nettype wire

[rtl/ptrd_core.sv]
// ============================================================================
// ptrd_core
// Countdowns, pending mask, cursor and deferred tick; computes one result.
// ============================================================================
`default_nettype none

module ptrd_core (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     advance,
   input  ptrd_pkg::item_type            item,
   input  ptrd_pkg::timing_arr_type      timing,
   input  ptrd_pkg::cfg_wr_type          cfg_wr,
   output ptrd_pkg::result_type          result
);

   typedef struct packed {
      logic                       found;
      logic [ptrd_pkg::IDX_W-1:0] idx;
   } search_type;

   typedef logic [ptrd_pkg::NUM_TASKS-1:0][ptrd_pkg::COUNT_BITS-1:0] cnt_arr_type;

   // field with zero read as one, taken modulo the counter width
   function automatic logic [ptrd_pkg::COUNT_BITS-1:0] field_of(
      input logic [ptrd_pkg::FIELD_BITS-1:0] f
   );
      logic [ptrd_pkg::COUNT_BITS-1:0] v;
      v = ptrd_pkg::COUNT_BITS'(f);
      if (v == '0) begin
         v = ptrd_pkg::COUNT_BITS'(1);
      end
      return v;
   endfunction

   function automatic logic [ptrd_pkg::COUNT_BITS-1:0] period_of(
      input logic [ptrd_pkg::TIMING_W-1:0] t
   );
      return field_of(t[ptrd_pkg::FIELD_BITS-1:0]);
   endfunction

   function automatic logic [ptrd_pkg::COUNT_BITS-1:0] offset_of(
      input logic [ptrd_pkg::TIMING_W-1:0] t
   );
      return field_of(t[ptrd_pkg::TIMING_W-1:ptrd_pkg::FIELD_BITS]);
   endfunction

   // lowest set bit at or above start
   function automatic search_type lowest_from(
      input logic [ptrd_pkg::NUM_TASKS-1:0] mask,
      input logic [ptrd_pkg::IDX_W:0]       start
   );
      search_type r;
      r = '0;
      for (int i = ptrd_pkg::NUM_TASKS - 1; i >= 0; i--) begin
         if (mask[i] && ((ptrd_pkg::IDX_W + 1)'(i) >= start)) begin
            r.found = 1'b1;
            r.idx   = ptrd_pkg::IDX_W'(i);
         end
      end
      return r;
   endfunction

   cnt_arr_type                         countdown_ff;
   cnt_arr_type                         countdown_in;
   logic [ptrd_pkg::NUM_TASKS-1:0]      pending_ff;
   logic [ptrd_pkg::NUM_TASKS-1:0]      pending_in;
   logic [ptrd_pkg::IDX_W-1:0]          cursor_ff;
   logic [ptrd_pkg::IDX_W-1:0]          cursor_in;
   logic                                deferred_ff;
   logic                                deferred_in;

   cnt_arr_type                         tk_cnt;
   logic [ptrd_pkg::NUM_TASKS-1:0]      tk_rel;

   // tick applied to every countdown in parallel
   always_comb begin
      logic [ptrd_pkg::COUNT_BITS-1:0] dec;
      for (int i = 0; i < ptrd_pkg::NUM_TASKS; i++) begin
         dec = countdown_ff[i] - 1'b1;
         if (dec == '0) begin
            tk_cnt[i] = period_of(timing[i]);
            tk_rel[i] = 1'b1;
         end else begin
            tk_cnt[i] = dec;
            tk_rel[i] = 1'b0;
         end
      end
   end

   // next state and result for the item at the input register
   always_comb begin
      logic [ptrd_pkg::NUM_TASKS-1:0] pend_r;
      logic [ptrd_pkg::NUM_TASKS-1:0] pend_f;
      search_type                     s1;
      search_type                     s2;
      logic [ptrd_pkg::IDX_W:0]       nxt_start;
      logic                           apply_def;

      countdown_in = countdown_ff;
      pending_in   = pending_ff;
      cursor_in    = cursor_ff;
      deferred_in  = deferred_ff;
      result       = '0;
      pend_r       = pending_ff;
      pend_f       = pending_ff;
      nxt_start    = {1'b0, cursor_ff} + 1'b1;
      apply_def    = 1'b0;

      // retire the cursor's task on a finished report
      if (item.task_done && (int'(cursor_ff) < ptrd_pkg::NUM_TASKS)) begin
         for (int i = 0; i < ptrd_pkg::NUM_TASKS; i++) begin
            if (cursor_ff == ptrd_pkg::IDX_W'(i)) begin
               pend_r[i] = 1'b0;
            end
         end
      end
      s1 = lowest_from(pend_r, nxt_start);
      s2 = lowest_from(tk_rel, '0);

      if (item.cmd == ptrd_pkg::CMD_TICK) begin
         if (pending_ff != '0) begin
            // defer; further ticks collapse and flag
            result.tick_overrun = deferred_ff;
            deferred_in         = 1'b1;
         end else begin
            countdown_in = tk_cnt;
            pend_f       = tk_rel;
            if (s2.found) begin
               cursor_in             = s2.idx;
               result.dispatch_valid = 1'b1;
               result.new_pass       = 1'b1;
               result.task_index     = s2.idx;
            end
         end
      end else if (pending_ff != '0) begin
         pend_f = pend_r;
         if (s1.found) begin
            cursor_in             = s1.idx;
            result.dispatch_valid = 1'b1;
            result.task_index     = s1.idx;
         end else begin
            // end of pass: wrap, applying a deferred tick once all retired
            apply_def = (pend_r == '0) && deferred_ff;
            if (apply_def) begin
               deferred_in  = 1'b0;
               countdown_in = tk_cnt;
               pend_f       = tk_rel;
               if (s2.found) begin
                  cursor_in             = s2.idx;
                  result.dispatch_valid = 1'b1;
                  result.new_pass       = 1'b1;
                  result.task_index     = s2.idx;
               end
            end else begin
               s2 = lowest_from(pend_r, '0);
               if (s2.found) begin
                  cursor_in             = s2.idx;
                  result.dispatch_valid = 1'b1;
                  result.new_pass       = 1'b1;
                  result.task_index     = s2.idx;
               end
            end
         end
      end

      pending_in      = pend_f;
      result.all_done = (pend_f == '0);

      // register write reloads that task's countdown
      if (cfg_wr.en) begin
         for (int i = 0; i < ptrd_pkg::NUM_TASKS; i++) begin
            if (cfg_wr.idx == ptrd_pkg::REG_IDX_W'(i)) begin
               countdown_in[i] = offset_of(cfg_wr.value);
            end
         end
      end
   end

   // state registers; items update state only when they move on
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ptrd_pkg::NUM_TASKS; i++) begin
            countdown_ff[i] <= offset_of(ptrd_pkg::TIMING_RESET[i]);
         end
         pending_ff  <= '0;
         cursor_ff   <= '0;
         deferred_ff <= 1'b0;
      end else if (advance) begin
         countdown_ff <= countdown_in;
         pending_ff   <= pending_in;
         cursor_ff    <= cursor_in;
         deferred_ff  <= deferred_in;
      end else if (cfg_wr.en) begin
         // no item moving: only the addressed countdown reloads
         for (int i = 0; i < ptrd_pkg::NUM_TASKS; i++) begin
            if (cfg_wr.idx == ptrd_pkg::REG_IDX_W'(i)) begin
               countdown_ff[i] <= offset_of(cfg_wr.value);
            end
         end
      end
   end

endmodule

`default_nettype wire
